FILE: rtl/core/tsh_pkg.sv
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared types, constants and helpers for the TCP/IPv4 segment header builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsh_pkg;

  // segment cut length and derived widths
  localparam int SEG_BYTES = 512;
  localparam int CNT_W     = $clog2(SEG_BYTES + 1);
  localparam int LEN_W     = 10;

  // header word sequencing
  localparam int HDR_WORDS = 10;
  localparam int IDX_W     = $clog2(HDR_WORDS);
  localparam int SUM_STEPS = 14;
  localparam int STEP_W    = $clog2(SUM_STEPS);

  // descriptor queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  // configuration port
  localparam int CFG_IDX_W = 3;

  // fixed header fields
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TTL        = 8'd123;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'h06;
  localparam logic [3:0]  TCP_DATA_OFF  = 4'd5;
  localparam logic [15:0] TCP_WINDOW    = 16'd400;
  localparam logic [15:0] HDR_BYTES     = 16'd40;
  localparam logic [15:0] TCP_HDR_BYTES = 16'd20;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_ADDR = 3'd0,
    REG_DST_ADDR = 3'd1,
    REG_SRC_PORT = 3'd2,
    REG_DST_PORT = 3'd3,
    REG_SEQ_BASE = 3'd4,
    REG_ACK_NUM  = 3'd5,
    REG_PKT_ID   = 3'd6,
    REG_FLAGS    = 3'd7
  } cfg_idx_t;

  // configuration register file
  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [31:0] sequence_base;
    logic [31:0] acknowledge_number;
    logic [15:0] packet_id;
    logic [7:0]  tcp_flags;
  } cfg_t;

  // one closed segment handed from front to back
  typedef struct packed {
    logic [15:0]      sum;
    logic [CNT_W-1:0] len;
    logic [15:0]      offset;
  } desc_t;

  // back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_EMIT
  } bk_state_t;

  // ones'-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tcp_segment_header_builder.sv
// ----------------------------------------------------------------------------
// tcp_segment_header_builder
// Cuts a payload byte stream into segments and emits the IPv4 and TCP
// headers of each segment as ten 32-bit words in network order.
// ----------------------------------------------------------------------------
// The input side takes one payload byte per cycle while the descriptor queue
// is not full; the payload checksum is one 16-bit end-around add per byte
// pair. Each closed segment leaves a descriptor in a four-entry queue. The
// back end takes a descriptor, folds the two header checksums one word per
// cycle, then emits the header words as the output register frees; with
// full-length segments the byte input runs at full rate, and a run of very
// short segments backs up into full. Results sit in an output register, so
// the input keeps moving while a word waits for pop. Registers are written
// through cfg_valid/cfg_ready (always ready) by the user only while the block
// is idle; the block does not enforce it. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_segment_header_builder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // payload side
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [7:0]                       payload_byte,
  input  wire logic                             buffer_end,
  // header side
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [31:0]                           header_word,
  output logic                                  header_last,
  output logic [tsh_pkg::LEN_W-1:0]             segment_length,
  // configuration
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tsh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                      cfg_data
);

  tsh_pkg::cfg_t  cfg;
  tsh_pkg::desc_t front_desc;
  tsh_pkg::desc_t q_desc;
  logic           desc_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (tsh_pkg::cfg_idx_t'(cfg_index))
        tsh_pkg::REG_SRC_ADDR: cfg.source_address      <= cfg_data;
        tsh_pkg::REG_DST_ADDR: cfg.destination_address <= cfg_data;
        tsh_pkg::REG_SRC_PORT: cfg.source_port         <= cfg_data[15:0];
        tsh_pkg::REG_DST_PORT: cfg.destination_port    <= cfg_data[15:0];
        tsh_pkg::REG_SEQ_BASE: cfg.sequence_base       <= cfg_data;
        tsh_pkg::REG_ACK_NUM:  cfg.acknowledge_number  <= cfg_data;
        tsh_pkg::REG_PKT_ID:   cfg.packet_id           <= cfg_data[15:0];
        tsh_pkg::REG_FLAGS:    cfg.tcp_flags           <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // byte intake and segmentation
  tsh_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .payload_byte (payload_byte),
    .buffer_end   (buffer_end),
    .desc_push    (desc_push),
    .desc         (front_desc),
    .q_full       (q_full)
  );

  // descriptor queue
  tsh_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (desc_push),
    .wr_data (front_desc),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_desc),
    .q_empty (q_empty)
  );

  // checksum and header word output
  tsh_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .desc           (q_desc),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .header_word    (header_word),
    .header_last    (header_last),
    .segment_length (segment_length)
  );

endmodule

`default_nettype wire

FILE: rtl/core/tsh_front.sv
// ----------------------------------------------------------------------------
// tsh_front
// Accepts payload bytes, keeps the payload checksum and segment count, and
// pushes one descriptor for every closed segment.
// ----------------------------------------------------------------------------
`default_nettype none

module tsh_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [7:0]      payload_byte,
  input  wire logic            buffer_end,
  output logic                 desc_push,
  output tsh_pkg::desc_t       desc,
  input  wire logic            q_full
);

  logic [15:0]               sum;
  logic [tsh_pkg::CNT_W-1:0] count;
  logic [15:0]               offset;
  logic [7:0]                held;
  logic                      odd;

  logic                      accept;
  logic [tsh_pkg::CNT_W-1:0] cnt_inc;
  logic                      close;
  logic [15:0]               word;
  logic [15:0]               sum_next;

  assign full   = q_full;
  assign accept = push && !q_full;

  // close on full segment or buffer end
  assign cnt_inc = count + tsh_pkg::CNT_W'(1);
  assign close   = (cnt_inc >= tsh_pkg::CNT_W'(tsh_pkg::SEG_BYTES)) || buffer_end;

  // pair with held byte, or pad a lone final byte with zero
  assign word     = odd ? {held, payload_byte} : {payload_byte, 8'h00};
  assign sum_next = tsh_pkg::oc_add(sum, word);

  assign desc_push  = accept && close;
  assign desc.sum    = sum_next;
  assign desc.len    = cnt_inc;
  assign desc.offset = offset;

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      count  <= '0;
      offset <= '0;
      held   <= '0;
      odd    <= 1'b0;
    end else if (accept) begin
      if (close) begin
        sum    <= '0;
        count  <= '0;
        held   <= '0;
        odd    <= 1'b0;
        offset <= buffer_end ? 16'd0 : offset + 16'(cnt_inc);
      end else begin
        count <= cnt_inc;
        if (odd) begin
          sum  <= sum_next;
          held <= '0;
          odd  <= 1'b0;
        end else begin
          held <= payload_byte;
          odd  <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsh_fifo.sv
// ----------------------------------------------------------------------------
// tsh_fifo
// Short descriptor queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tsh_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire tsh_pkg::desc_t   wr_data,
  output logic                  q_full,
  input  wire logic             rd_en,
  output tsh_pkg::desc_t        rd_data,
  output logic                  q_empty
);

  tsh_pkg::desc_t              mem [tsh_pkg::Q_DEPTH];
  logic [tsh_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [tsh_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [tsh_pkg::Q_PTR_W:0]   fill;

  logic do_wr;
  logic do_rd;

  assign q_full  = (fill == (tsh_pkg::Q_PTR_W+1)'(tsh_pkg::Q_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + tsh_pkg::Q_PTR_W'(1);
      if (do_rd) rd_ptr <= rd_ptr + tsh_pkg::Q_PTR_W'(1);
      if (do_wr && !do_rd) begin
        fill <= fill + (tsh_pkg::Q_PTR_W+1)'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - (tsh_pkg::Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tsh_back.sv
// ----------------------------------------------------------------------------
// tsh_back
// Takes one segment descriptor at a time, folds the IPv4 and TCP checksums
// one word per cycle, then streams the ten header words through an output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsh_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire tsh_pkg::cfg_t              cfg,
  input  wire tsh_pkg::desc_t             desc,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [31:0]                     header_word,
  output logic                            header_last,
  output logic [tsh_pkg::LEN_W-1:0]       segment_length
);

  tsh_pkg::bk_state_t         state;
  tsh_pkg::bk_state_t         state_next;
  tsh_pkg::desc_t             cur;
  logic [31:0]                seq;
  logic [15:0]                ip_sum;
  logic [15:0]                tcp_sum;
  logic [tsh_pkg::STEP_W-1:0] step;
  logic [tsh_pkg::IDX_W-1:0]  idx;
  logic                       out_valid;

  logic        calc_en;
  logic        load_word;
  logic        out_free;
  logic        last_step;
  logic        last_idx;
  logic [15:0] ip_w;
  logic [15:0] tcp_w;
  logic [15:0] total_len;
  logic [15:0] tcp_len;
  logic [31:0] word;

  assign out_free  = !out_valid || pop;
  assign last_step = (step == tsh_pkg::STEP_W'(tsh_pkg::SUM_STEPS - 1));
  assign last_idx  = (idx == tsh_pkg::IDX_W'(tsh_pkg::HDR_WORDS - 1));
  assign total_len = tsh_pkg::HDR_BYTES + 16'(cur.len);
  assign tcp_len   = tsh_pkg::TCP_HDR_BYTES + 16'(cur.len);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tsh_pkg::BK_IDLE: if (!q_empty) state_next = tsh_pkg::BK_CALC;
      tsh_pkg::BK_CALC: if (last_step) state_next = tsh_pkg::BK_EMIT;
      tsh_pkg::BK_EMIT: if (out_free && last_idx) state_next = tsh_pkg::BK_IDLE;
      default:          state_next = tsh_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    calc_en   = 1'b0;
    load_word = 1'b0;
    case (state)
      tsh_pkg::BK_IDLE: q_pop     = !q_empty;
      tsh_pkg::BK_CALC: calc_en   = 1'b1;
      tsh_pkg::BK_EMIT: load_word = out_free;
      default: ;
    endcase
  end

  // IPv4 header words; order does not matter to a ones'-complement sum
  always_comb begin
    case (step)
      4'd0:    ip_w = {tsh_pkg::IP_VER_IHL, 8'h00};
      4'd1:    ip_w = total_len;
      4'd2:    ip_w = cfg.packet_id;
      4'd3:    ip_w = {tsh_pkg::IP_TTL, tsh_pkg::IP_PROTO_TCP};
      4'd4:    ip_w = cfg.source_address[31:16];
      4'd5:    ip_w = cfg.source_address[15:0];
      4'd6:    ip_w = cfg.destination_address[31:16];
      4'd7:    ip_w = cfg.destination_address[15:0];
      default: ip_w = 16'h0000;
    endcase
  end

  // pseudo header and TCP header words
  always_comb begin
    case (step)
      4'd0:    tcp_w = cfg.source_address[31:16];
      4'd1:    tcp_w = cfg.source_address[15:0];
      4'd2:    tcp_w = cfg.destination_address[31:16];
      4'd3:    tcp_w = cfg.destination_address[15:0];
      4'd4:    tcp_w = {8'h00, tsh_pkg::IP_PROTO_TCP};
      4'd5:    tcp_w = tcp_len;
      4'd6:    tcp_w = cfg.source_port;
      4'd7:    tcp_w = cfg.destination_port;
      4'd8:    tcp_w = seq[31:16];
      4'd9:    tcp_w = seq[15:0];
      4'd10:   tcp_w = cfg.acknowledge_number[31:16];
      4'd11:   tcp_w = cfg.acknowledge_number[15:0];
      4'd12:   tcp_w = {tsh_pkg::TCP_DATA_OFF, 4'h0, cfg.tcp_flags};
      4'd13:   tcp_w = tsh_pkg::TCP_WINDOW;
      default: tcp_w = 16'h0000;
    endcase
  end

  // header word select
  always_comb begin
    case (idx)
      4'd0:    word = {tsh_pkg::IP_VER_IHL, 8'h00, total_len};
      4'd1:    word = {cfg.packet_id, 16'h0000};
      4'd2:    word = {tsh_pkg::IP_TTL, tsh_pkg::IP_PROTO_TCP, ~ip_sum};
      4'd3:    word = cfg.source_address;
      4'd4:    word = cfg.destination_address;
      4'd5:    word = {cfg.source_port, cfg.destination_port};
      4'd6:    word = seq;
      4'd7:    word = cfg.acknowledge_number;
      4'd8:    word = {tsh_pkg::TCP_DATA_OFF, 4'h0, cfg.tcp_flags, tsh_pkg::TCP_WINDOW};
      4'd9:    word = {~tcp_sum, 16'h0000};
      default: word = 32'h0000_0000;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsh_pkg::BK_IDLE;
      step      <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop)   step <= '0;
      if (calc_en) step <= step + tsh_pkg::STEP_W'(1);
      if (calc_en && last_step) idx <= '0;
      if (load_word) idx <= idx + tsh_pkg::IDX_W'(1);
      if (load_word) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // descriptor capture and checksum accumulation
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= desc;
      seq     <= cfg.sequence_base + {16'h0000, desc.offset};
      ip_sum  <= 16'h0000;
      tcp_sum <= desc.sum;
    end
    if (calc_en) begin
      ip_sum  <= tsh_pkg::oc_add(ip_sum, ip_w);
      tcp_sum <= tsh_pkg::oc_add(tcp_sum, tcp_w);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_word) begin
      header_word    <= word;
      header_last    <= last_idx;
      segment_length <= tsh_pkg::LEN_W'(cur.len);
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives payload bytes into the TCP/IPv4 segment header builder and checks
// every header beat against an in-bench model of segmentation, the IPv4
// header checksum and the TCP checksum. Random bytes, buffer ends, register
// settings and idle gaps on both sides, plus a long receiver stall that
// fills the block.
// ----------------------------------------------------------------------------

module testbench;

  // header field constants, as they go on the wire
  localparam int unsigned SEGMENT_MAX  = 512;
  localparam logic [7:0]  VER_IHL      = 8'h45;
  localparam logic [7:0]  TTL_VALUE    = 8'd123;
  localparam logic [7:0]  PROTO_TCP    = 8'h06;
  localparam logic [3:0]  TCP_OFFSET   = 4'd5;
  localparam logic [15:0] WINDOW_SIZE  = 16'd400;
  localparam int unsigned IPV4_HDR_LEN = 40;
  localparam int unsigned TCP_HDR_LEN  = 20;

  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 600;

  typedef struct {
    logic [31:0]               word;
    logic                      last;
    logic [tsh_pkg::LEN_W-1:0] len;
  } header_beat_t;

  typedef enum {REGS_ZERO, REGS_ONES, REGS_RANDOM} reg_pattern_t;

  // --------------------------------------------------------------------------
  // Header model and result checker
  // --------------------------------------------------------------------------
  class header_checker;
    tsh_pkg::cfg_t regs;
    logic [15:0]   payload_sum;
    int unsigned   seg_bytes;
    logic [15:0]   buf_offset;
    logic [7:0]    held_byte;
    bit            odd_byte;
    header_beat_t  expected_words[$];
    int unsigned   mismatches;

    function new();
      regs        = '0;
      payload_sum = '0;
      seg_bytes   = 0;
      buf_offset  = '0;
      held_byte   = '0;
      odd_byte    = 1'b0;
      mismatches  = 0;
    endfunction

    // end-around 16-bit add
    function logic [15:0] csum_add(logic [15:0] acc, logic [15:0] w);
      int unsigned t;
      t = acc + w;
      return 16'((t & 32'h0000_ffff) + (t >> 16));
    endfunction

    function logic [15:0] csum_add32(logic [15:0] acc, logic [31:0] w);
      return csum_add(csum_add(acc, w[31:16]), w[15:0]);
    endfunction

    function void write_reg(tsh_pkg::cfg_idx_t idx, logic [31:0] d);
      case (idx)
        tsh_pkg::REG_SRC_ADDR: regs.source_address      = d;
        tsh_pkg::REG_DST_ADDR: regs.destination_address = d;
        tsh_pkg::REG_SRC_PORT: regs.source_port         = d[15:0];
        tsh_pkg::REG_DST_PORT: regs.destination_port    = d[15:0];
        tsh_pkg::REG_SEQ_BASE: regs.sequence_base       = d;
        tsh_pkg::REG_ACK_NUM:  regs.acknowledge_number  = d;
        tsh_pkg::REG_PKT_ID:   regs.packet_id           = d[15:0];
        tsh_pkg::REG_FLAGS:    regs.tcp_flags           = d[7:0];
        default: ;
      endcase
    endfunction

    // one accepted payload byte; a closing byte queues ten header beats
    function void note_byte(logic [7:0] b, logic e);
      logic [31:0]  w [10];
      logic [15:0]  ip_sum;
      logic [15:0]  tcp_sum;
      int unsigned  len;
      header_beat_t beat;

      if (odd_byte) begin
        payload_sum = csum_add(payload_sum, {held_byte, b});
        odd_byte    = 1'b0;
        held_byte   = '0;
      end else begin
        held_byte = b;
        odd_byte  = 1'b1;
      end
      seg_bytes++;
      if (seg_bytes < SEGMENT_MAX && !e) return;

      // odd tail byte is padded with a zero low byte
      if (odd_byte) begin
        payload_sum = csum_add(payload_sum, {held_byte, 8'h00});
        odd_byte    = 1'b0;
        held_byte   = '0;
      end
      len = seg_bytes;

      // IPv4 header
      w[0] = {VER_IHL, 8'h00, 16'(IPV4_HDR_LEN + len)};
      w[1] = {regs.packet_id, 16'h0000};
      w[2] = {TTL_VALUE, PROTO_TCP, 16'h0000};
      w[3] = regs.source_address;
      w[4] = regs.destination_address;
      ip_sum = '0;
      for (int k = 0; k < 5; k++) ip_sum = csum_add32(ip_sum, w[k]);
      w[2][15:0] = ~ip_sum;

      // TCP header
      w[5] = {regs.source_port, regs.destination_port};
      w[6] = regs.sequence_base + {16'h0000, buf_offset};
      w[7] = regs.acknowledge_number;
      w[8] = {TCP_OFFSET, 4'h0, regs.tcp_flags, WINDOW_SIZE};

      // pseudo header, TCP header and payload
      tcp_sum = payload_sum;
      tcp_sum = csum_add32(tcp_sum, regs.source_address);
      tcp_sum = csum_add32(tcp_sum, regs.destination_address);
      tcp_sum = csum_add(tcp_sum, {8'h00, PROTO_TCP});
      tcp_sum = csum_add(tcp_sum, 16'(TCP_HDR_LEN + len));
      for (int k = 5; k < 9; k++) tcp_sum = csum_add32(tcp_sum, w[k]);
      w[9] = {~tcp_sum, 16'h0000};

      for (int k = 0; k < 10; k++) begin
        beat.word = w[k];
        beat.last = (k == 9);
        beat.len  = tsh_pkg::LEN_W'(len);
        expected_words.push_back(beat);
      end

      buf_offset  = e ? 16'h0000 : 16'(buf_offset + len);
      payload_sum = '0;
      seg_bytes   = 0;
    endfunction

    function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    endfunction

    // one accepted header beat against the oldest expectation
    function void check_word(logic [31:0] word, logic last,
                             logic [tsh_pkg::LEN_W-1:0] len);
      header_beat_t exp_beat;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected header beat, expected none, got %h last %b len %0d",
                 $time, word, last, len);
        return;
      end
      exp_beat = expected_words.pop_front();
      if (word !== exp_beat.word) report("header_word", exp_beat.word, word);
      if (last !== exp_beat.last) report("header_last", 32'(exp_beat.last), 32'(last));
      if (len !== exp_beat.len) report("segment_length", 32'(exp_beat.len), 32'(len));
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          push         = 1'b0;
  logic                          full;
  logic [7:0]                    payload_byte = '0;
  logic                          buffer_end   = 1'b0;
  logic                          empty;
  logic                          pop          = 1'b0;
  logic [31:0]                   header_word;
  logic                          header_last;
  logic [tsh_pkg::LEN_W-1:0]     segment_length;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic [tsh_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [31:0]                   cfg_data     = '0;

  header_checker hdr = new();
  int unsigned   hold_request = 0;
  int unsigned   quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tcp_segment_header_builder DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .payload_byte   (payload_byte),
    .buffer_end     (buffer_end),
    .empty          (empty),
    .pop            (pop),
    .header_word    (header_word),
    .header_last    (header_last),
    .segment_length (segment_length),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Monitor: register writes, header beats, payload beats, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        hdr.write_reg(tsh_pkg::cfg_idx_t'(cfg_index), cfg_data);
      if (pop && !empty) hdr.check_word(header_word, header_last, segment_length);
      if (push && !full) hdr.note_byte(payload_byte, buffer_end);

      if ((cfg_valid && cfg_ready) || (pop && !empty) || (push && !full))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random pop stalls plus an occasional long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left != 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) stall_left = idle_len();
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  task automatic push_byte(logic [7:0] b, logic e);
    int unsigned gap;
    @(negedge clk);
    push         <= 1'b1;
    payload_byte <= b;
    buffer_end   <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    gap = idle_len();
    if (gap != 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop sending, let all headers come out, then let the back end settle
  task automatic drain_headers();
    @(negedge clk);
    push <= 1'b0;
    while (hdr.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(reg_pattern_t pattern);
    tsh_pkg::cfg_idx_t r;
    logic [31:0]       v;
    int unsigned       pick;
    r = r.first();
    do begin
      case (pattern)
        REGS_ZERO: v = '0;
        REGS_ONES: v = '1;
        default: begin
          pick = $urandom_range(0, 9);
          v = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hffff_ffff : $urandom();
        end
      endcase
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= v;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      r = r.next();
    end while (r != r.first());
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: a two-byte segment whose TCP checksum comes out zero,
    // odd single bytes, all-ones bytes, then leave a segment open
    push_byte(8'hae, 1'b0);
    push_byte(8'h53, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'haa, 1'b0);
    push_byte(8'h01, 1'b0);
    drain_headers();

    // registers change under the open segment; it closes with the new ones
    program_regs(REGS_ONES);
    push_byte(8'h80, 1'b1);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);
    push_byte(8'h7f, 1'b0);
    push_byte(8'hfe, 1'b1);
    drain_headers();

    // receiver holds off while short segments pile up against full
    program_regs(REGS_RANDOM);
    hold_request = LONG_HOLD;
    for (int i = 0; i < 40; i++)
      push_byte(8'($urandom()), ($urandom_range(0, 4) != 0));
    drain_headers();

    // random phases, each under its own register setting
    for (int p = 0; p < 4; p++) begin
      program_regs((p == 3) ? REGS_ZERO : REGS_RANDOM);
      for (int i = 0; i < 12; i++)
        push_byte(8'($urandom()), ($urandom_range(0, 3) == 0));
      drain_headers();
    end

    if (hdr.mismatches == 0 && hdr.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: tcp_segment_header_builder.f
rtl/core/tsh_pkg.sv
rtl/core/tsh_front.sv
rtl/core/tsh_fifo.sv
rtl/core/tsh_back.sv
rtl/core/tcp_segment_header_builder.sv
sim/testbench.sv
